>>> sv/istp_pkg.sv
// Shared types, character codes and sizes for the inline style tag parser.
package istp_pkg;

  // Sizes of the tag buffers and the override stacks.
  localparam int unsigned StackDepth  = 4;
  localparam int unsigned NameBuffer  = 16;
  localparam int unsigned ValueBuffer = 32;

  localparam int unsigned StackCntW = $clog2(StackDepth + 1);
  localparam int unsigned StackIdxW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned NameLenW  = $clog2(NameBuffer);
  localparam int unsigned ValueLenW = $clog2(ValueBuffer);
  localparam int unsigned NameMax   = NameBuffer - 1;
  localparam int unsigned ValueMax  = ValueBuffer - 1;

  // Only the first bytes of a name can take part in a match: the longest
  // known tag name has five characters.
  localparam int unsigned NameKeep  = 5;
  localparam int unsigned NameKeepW = $clog2(NameKeep);

  // Code points with a meaning to the tag scanner.
  localparam logic [20:0] CpNul   = 21'h00;
  localparam logic [20:0] CpSpace = 21'h20;
  localparam logic [20:0] CpSlash = 21'h2F;
  localparam logic [20:0] CpLt    = 21'h3C;
  localparam logic [20:0] CpEq    = 21'h3D;
  localparam logic [20:0] CpGt    = 21'h3E;

  // Known tag names, first character in the top byte, padded with zeros.
  localparam logic [NameKeep*8-1:0] WordFont  = {"font", 8'h00};
  localparam logic [NameKeep*8-1:0] WordColor = "color";
  localparam logic [NameKeep*8-1:0] WordB     = {"b", 32'h0};
  localparam logic [NameKeep*8-1:0] WordI     = {"i", 32'h0};
  localparam logic [NameKeep*8-1:0] WordU     = {"u", 32'h0};
  localparam logic [NameKeep*8-1:0] WordS     = {"s", 32'h0};
  localparam logic [NameKeep*8-1:0] WordDel   = {"del", 16'h0};

  // Phases of the base-16 value conversion.
  localparam logic [2:0] PhLead   = 3'd0;
  localparam logic [2:0] PhSigned = 3'd1;
  localparam logic [2:0] PhZero   = 3'd2;
  localparam logic [2:0] PhDigits = 3'd3;
  localparam logic [2:0] PhDone   = 3'd4;

  typedef enum logic [2:0] {
    TagNone,
    TagFont,
    TagColor,
    TagBold,
    TagItalic,
    TagUnder,
    TagStrike
  } tag_kind_e;

  typedef logic [NameKeep-1:0][7:0] name_keep_t;

  typedef struct packed {
    name_keep_t          bytes;
    logic [NameLenW-1:0] len;
    logic                non_ascii;
  } name_st_t;

  typedef struct packed {
    logic [63:0] acc;
    logic [2:0]  phase;
    logic        neg;
    logic        sat;
  } val_st_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        start_of_text;
  } in_t;

  typedef struct packed {
    logic        is_markup;
    logic        tag_edge;
    logic [3:0]  style_bits;
    logic [63:0] font_value;
    logic [63:0] color_value;
    logic        stack_overflow;
  } out_t;

endpackage

>>> sv/istp_value_step.sv
// One byte step of the base-16 value conversion of a tag value.
module istp_value_step (
  input  istp_pkg::val_st_t cur_i,
  input  logic [7:0]        data_byte_i,
  output istp_pkg::val_st_t nxt_o
);
  import istp_pkg::*;

  logic       hex_ok;
  logic [3:0] hex_val;
  logic       is_ws;
  logic       do_signed;
  logic       do_digits;
  val_st_t    nxt;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'h0;
    if (data_byte_i >= "0" && data_byte_i <= "9") begin
      hex_val = 4'(data_byte_i - 8'h30);
    end else if (data_byte_i >= "a" && data_byte_i <= "f") begin
      hex_val = 4'(data_byte_i - 8'h57);
    end else if (data_byte_i >= "A" && data_byte_i <= "F") begin
      hex_val = 4'(data_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign is_ws = (data_byte_i >= 8'h09) && (data_byte_i <= 8'h0D);

  always_comb begin
    nxt       = cur_i;
    do_signed = 1'b0;
    do_digits = 1'b0;
    unique case (cur_i.phase)
      PhLead: begin
        if (data_byte_i == "+") begin
          nxt.phase = PhSigned;
        end else if (data_byte_i == "-") begin
          nxt.neg   = 1'b1;
          nxt.phase = PhSigned;
        end else if (!is_ws) begin
          do_signed = 1'b1;
        end
      end
      PhSigned: begin
        do_signed = 1'b1;
      end
      PhZero: begin
        if (data_byte_i == "x" || data_byte_i == "X") begin
          nxt.phase = PhDigits;
        end else begin
          do_digits = 1'b1;
        end
      end
      PhDigits: begin
        do_digits = 1'b1;
      end
      default: begin
      end
    endcase

    // A leading zero only moves to the prefix check; it adds nothing yet.
    if (do_signed) begin
      if (data_byte_i == "0") begin
        nxt.phase = PhZero;
      end else if (hex_ok) begin
        do_digits = 1'b1;
      end else begin
        nxt.phase = PhDone;
      end
    end

    if (do_digits) begin
      if (hex_ok) begin
        nxt.phase = PhDigits;
        if (!cur_i.sat) begin
          if (cur_i.acc[63:60] != 4'h0) begin
            nxt.sat = 1'b1;
          end else begin
            nxt.acc = {cur_i.acc[59:0], hex_val};
          end
        end
      end else begin
        nxt.phase = PhDone;
      end
    end
  end

  assign nxt_o = nxt;

endmodule

>>> sv/istp_tag_match.sv
// Case-insensitive match of a collected tag name against the known tags.
module istp_tag_match (
  input  istp_pkg::name_st_t  name_i,
  output istp_pkg::tag_kind_e kind_o
);
  import istp_pkg::*;

  // Stored bytes are already lower case.
  function automatic logic name_is(name_st_t n, logic [NameKeep*8-1:0] word,
                                   int unsigned wlen);
    logic eq;
    eq = !n.non_ascii && (int'(n.len) == int'(wlen));
    for (int unsigned k = 0; k < NameKeep; k++) begin
      if (k < wlen && n.bytes[k] != word[(NameKeep-1-k)*8 +: 8]) begin
        eq = 1'b0;
      end
    end
    return eq;
  endfunction

  always_comb begin
    priority if (name_is(name_i, WordFont, 4)) begin
      kind_o = TagFont;
    end else if (name_is(name_i, WordColor, 5)) begin
      kind_o = TagColor;
    end else if (name_is(name_i, WordB, 1)) begin
      kind_o = TagBold;
    end else if (name_is(name_i, WordI, 1)) begin
      kind_o = TagItalic;
    end else if (name_is(name_i, WordU, 1)) begin
      kind_o = TagUnder;
    end else if (name_is(name_i, WordS, 1) || name_is(name_i, WordDel, 3)) begin
      kind_o = TagStrike;
    end else begin
      kind_o = TagNone;
    end
  end

endmodule

>>> sv/inline_style_tag_parser.sv
// Top level of the inline style tag parser: scanner, tag state, stacks and result register.
//
//   Channel | Direction | Signals                          | Transfer when
//   --------+-----------+----------------------------------+-------------------------
//   in      | input     | in_valid_i, in_stall_o, in_data_i | in_valid_i && !in_stall_o
//   out     | output    | out_valid_o, out_stall_i, out_data_o | out_valid_o && !out_stall_i
//
// The tag state, the stacks and the result register all load at the edge that
// takes the input transfer, and the result is offered in the next cycle. A new
// code point can be taken every cycle. The input stalls only while a result is
// held and the output side stalls. Reset clears the tag scanner, the stack
// depths, the style bits and the result valid; stack contents and name bytes
// are never cleared.
module inline_style_tag_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  istp_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output istp_pkg::out_t  out_data_o
);
  import istp_pkg::*;

  // Handshake. The result register is free when it is empty or being drained.
  logic in_xfer;
  logic out_valid_q;
  out_t out_q;
  out_t out_d;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Tag scanner state.
  logic                 open_q, open_d, open_c;
  logic                 closing_q, closing_d, closing_c;
  logic                 coll_q, coll_d, coll_c;
  logic [NameLenW-1:0]  nlen_q, nlen_d, nlen_c;
  logic                 nna_q, nna_d, nna_c;
  name_keep_t           name_bytes_q;
  val_st_t              val_q, val_d, val_c, val_step;
  logic [ValueLenW-1:0] vlen_q, vlen_d, vlen_c;

  // Stacks and style.
  logic [63:0]          font_q [StackDepth];
  logic [63:0]          color_q [StackDepth];
  logic [StackCntW-1:0] fdep_q, fdep_d, fdep_c;
  logic [StackCntW-1:0] cdep_q, cdep_d, cdep_c;
  logic [3:0]           style_q, style_d, style_c;

  // Per-character decode.
  logic [20:0]          cp;
  logic                 sot;
  logic                 is_ascii;
  logic [2:0]           utf_len;
  logic [7:0]           lc_byte;
  logic [7:0]           feed_byte;
  logic                 edge_flag;
  logic                 apply;
  logic                 overflow;
  logic                 name_we;
  logic [NameLenW:0]    nlen_sum;
  logic [ValueLenW:0]   vlen_sum;
  logic [63:0]          parsed;
  name_st_t             name_cur;
  tag_kind_e            kind;
  logic                 font_push, color_push;
  logic [StackCntW-1:0] fdep_m1, cdep_m1;
  logic [63:0]          font_top, color_top;

  assign cp  = in_data_i.code_point;
  assign sot = in_data_i.start_of_text;

  // Start of text wipes the scanner, depths and style before this character.
  assign open_c    = open_q & ~sot;
  assign closing_c = closing_q & ~sot;
  assign coll_c    = coll_q & ~sot;
  assign nlen_c    = sot ? '0 : nlen_q;
  assign nna_c     = nna_q & ~sot;
  assign val_c     = sot ? val_st_t'{acc: '0, phase: PhLead, neg: 1'b0, sat: 1'b0} : val_q;
  assign vlen_c    = sot ? '0 : vlen_q;
  assign fdep_c    = sot ? '0 : fdep_q;
  assign cdep_c    = sot ? '0 : cdep_q;
  assign style_c   = sot ? '0 : style_q;

  // UTF-8 byte count of a non-zero code point, and its lead byte class.
  assign is_ascii = (cp < 21'h80);
  always_comb begin
    if (is_ascii) begin
      utf_len = 3'd1;
    end else if (cp < 21'h800) begin
      utf_len = 3'd2;
    end else if (cp < 21'h10000) begin
      utf_len = 3'd3;
    end else begin
      utf_len = 3'd4;
    end
  end

  assign lc_byte = (cp[7:0] >= "A" && cp[7:0] <= "Z") ? (cp[7:0] | 8'h20) : cp[7:0];

  // Any lead byte at or above 0x80 ends the number, so one marker byte
  // stands in for the whole multi-byte sequence.
  assign feed_byte = is_ascii ? cp[7:0] : 8'h80;

  istp_value_step u_value (
    .cur_i       (val_c),
    .data_byte_i (feed_byte),
    .nxt_o       (val_step)
  );

  assign name_cur = '{bytes: name_bytes_q, len: nlen_c, non_ascii: nna_c};

  istp_tag_match u_match (
    .name_i (name_cur),
    .kind_o (kind)
  );

  assign nlen_sum = {1'b0, nlen_c} + (NameLenW + 1)'(utf_len);
  assign vlen_sum = {1'b0, vlen_c} + (ValueLenW + 1)'(utf_len);

  assign parsed = val_c.sat ? '1 : (val_c.neg ? (64'd0 - val_c.acc) : val_c.acc);

  // Scanner next state.
  always_comb begin
    open_d    = open_c;
    closing_d = closing_c;
    coll_d    = coll_c;
    nlen_d    = nlen_c;
    nna_d     = nna_c;
    val_d     = val_c;
    vlen_d    = vlen_c;
    edge_flag = 1'b0;
    apply     = 1'b0;
    name_we   = 1'b0;
    if (!open_c) begin
      if (cp == CpLt) begin
        open_d    = 1'b1;
        closing_d = 1'b0;
        coll_d    = 1'b1;
        nlen_d    = '0;
        nna_d     = 1'b0;
        val_d     = '{acc: '0, phase: PhLead, neg: 1'b0, sat: 1'b0};
        vlen_d    = '0;
        edge_flag = 1'b1;
      end
    end else if (cp == CpSlash) begin
      closing_d = 1'b1;
    end else if (cp == CpGt) begin
      open_d    = 1'b0;
      edge_flag = 1'b1;
      apply     = 1'b1;
    end else if (cp == CpEq && coll_c) begin
      coll_d = 1'b0;
    end else if (cp != CpSpace && cp != CpNul) begin
      if (coll_c) begin
        if (int'(nlen_c) < NameMax) begin
          name_we = is_ascii && (int'(nlen_c) < NameKeep);
          nna_d   = nna_c | ~is_ascii;
          nlen_d  = (int'(nlen_sum) > NameMax) ? NameLenW'(NameMax)
                                               : nlen_sum[NameLenW-1:0];
        end
      end else if (int'(vlen_c) < ValueMax) begin
        val_d  = val_step;
        vlen_d = (int'(vlen_sum) > ValueMax) ? ValueLenW'(ValueMax)
                                             : vlen_sum[ValueLenW-1:0];
      end
    end
  end

  // Applying a tag on its closing '>'.
  always_comb begin
    fdep_d     = fdep_c;
    cdep_d     = cdep_c;
    style_d    = style_c;
    overflow   = 1'b0;
    font_push  = 1'b0;
    color_push = 1'b0;
    if (apply) begin
      unique case (kind)
        TagFont: begin
          if (closing_c) begin
            if (fdep_c != '0) begin
              fdep_d = fdep_c - StackCntW'(1);
            end
          end else if (fdep_c >= StackCntW'(StackDepth)) begin
            overflow = 1'b1;
          end else begin
            font_push = 1'b1;
            fdep_d    = fdep_c + StackCntW'(1);
          end
        end
        TagColor: begin
          if (closing_c) begin
            if (cdep_c != '0) begin
              cdep_d = cdep_c - StackCntW'(1);
            end
          end else if (cdep_c >= StackCntW'(StackDepth)) begin
            overflow = 1'b1;
          end else begin
            color_push = 1'b1;
            cdep_d     = cdep_c + StackCntW'(1);
          end
        end
        TagBold: begin
          style_d[0] = ~closing_c;
        end
        TagItalic: begin
          style_d[1] = ~closing_c;
        end
        TagUnder: begin
          style_d[2] = ~closing_c;
        end
        TagStrike: begin
          style_d[3] = ~closing_c;
        end
        default: begin
        end
      endcase
    end
  end

  // Top of each stack after this character. A push shows the pushed value.
  assign fdep_m1 = fdep_d - StackCntW'(1);
  assign cdep_m1 = cdep_d - StackCntW'(1);

  always_comb begin
    if (fdep_d == '0) begin
      font_top = '0;
    end else if (font_push) begin
      font_top = parsed;
    end else begin
      font_top = font_q[StackIdxW'(fdep_m1)];
    end
    if (cdep_d == '0) begin
      color_top = '0;
    end else if (color_push) begin
      color_top = parsed;
    end else begin
      color_top = color_q[StackIdxW'(cdep_m1)];
    end
  end

  always_comb begin
    out_d.is_markup      = edge_flag | open_d;
    out_d.tag_edge       = edge_flag;
    out_d.style_bits     = style_d;
    out_d.font_value     = font_top;
    out_d.color_value    = color_top;
    out_d.stack_overflow = overflow;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      closing_q   <= 1'b0;
      coll_q      <= 1'b0;
      nlen_q      <= '0;
      nna_q       <= 1'b0;
      val_q       <= '{acc: '0, phase: PhLead, neg: 1'b0, sat: 1'b0};
      vlen_q      <= '0;
      fdep_q      <= '0;
      cdep_q      <= '0;
      style_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        open_q      <= open_d;
        closing_q   <= closing_d;
        coll_q      <= coll_d;
        nlen_q      <= nlen_d;
        nna_q       <= nna_d;
        val_q       <= val_d;
        vlen_q      <= vlen_d;
        fdep_q      <= fdep_d;
        cdep_q      <= cdep_d;
        style_q     <= style_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload storage: name bytes, stack entries and the result.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
      if (name_we) begin
        name_bytes_q[NameKeepW'(nlen_c)] <= lc_byte;
      end
      if (font_push) begin
        font_q[StackIdxW'(fdep_c)] <= parsed;
      end
      if (color_push) begin
        color_q[StackIdxW'(cdep_c)] <= parsed;
      end
    end
  end

endmodule
